@@ hdl/pvc_pkg.sv @@
// shared types and constants for the prefix-length varint codec
// no dependencies; used by all pvc modules
package pvc_pkg;

  typedef enum logic [1:0] {
    KIND_BYTE    = 2'd0,
    KIND_NUMBER  = 2'd1,
    KIND_ENC_ERR = 2'd2,
    KIND_DEC_ERR = 2'd3
  } kind_t;

  typedef enum logic {
    OP_ENCODE = 1'b0,
    OP_DECODE = 1'b1
  } op_t;

  // encode range limits, one per length
  localparam logic [31:0] ENC_LIM1 = 32'd128;
  localparam logic [31:0] ENC_LIM2 = 32'd16384;
  localparam logic [31:0] ENC_LIM3 = 32'd2097152;
  localparam logic [31:0] ENC_LIM4 = 32'd268435456;

  // length prefixes placed over the value bits
  localparam logic [31:0] ENC_PFX2 = 32'd32768;
  localparam logic [31:0] ENC_PFX3 = 32'd12582912;
  localparam logic [31:0] ENC_PFX4 = 32'd3758096384;

  // one queued job: up to four result words
  typedef struct packed {
    kind_t       kind;
    logic [1:0]  len_m1;  // result words minus one
    logic [31:0] data;    // prefixed code word or decoded number
  } job_t;

endpackage

@@ hdl/pvc_if.sv @@
// valid/ready channel interfaces for the varint codec input and result words
// no dependencies
interface pvc_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [31:0] value;
  logic [7:0]  in_byte;

  modport source (output valid, output op, output value, output in_byte, input ready);
  modport sink   (input valid, input op, input value, input in_byte, output ready);
endinterface

interface pvc_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  out_byte;
  logic [27:0] number;
  logic        last;

  modport source (output valid, output kind, output out_byte, output number, output last,
                  input ready);
  modport sink   (input valid, input kind, input out_byte, input number, input last,
                  output ready);
endinterface

@@ hdl/pvc_front.sv @@
// front end: accepts input words, runs the decode state, builds queue jobs
// depends on pvc_pkg and pvc_in_if
module pvc_front (
  input  logic          clk,
  input  logic          rst_n,
  pvc_in_if.sink        in_ch,
  input  logic          q_full,
  output logic          push,
  output pvc_pkg::job_t push_job
);
  import pvc_pkg::*;

  logic [1:0]  bytes_left_r, bytes_left_nxt;
  logic [27:0] acc_r, acc_nxt;
  logic        has_result;
  logic        accept;
  logic [7:0]  b;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign push        = accept && has_result;
  assign b           = in_ch.in_byte;

  always_comb begin
    bytes_left_nxt  = bytes_left_r;
    acc_nxt         = acc_r;
    has_result      = 1'b0;
    push_job.kind   = KIND_BYTE;
    push_job.len_m1 = 2'd0;
    push_job.data   = 32'd0;
    if (in_ch.op == OP_ENCODE) begin
      has_result = 1'b1;
      if (in_ch.value < ENC_LIM1) begin
        push_job.data = in_ch.value;
      end else if (in_ch.value < ENC_LIM2) begin
        push_job.data   = in_ch.value | ENC_PFX2;
        push_job.len_m1 = 2'd1;
      end else if (in_ch.value < ENC_LIM3) begin
        push_job.data   = in_ch.value | ENC_PFX3;
        push_job.len_m1 = 2'd2;
      end else if (in_ch.value < ENC_LIM4) begin
        push_job.data   = in_ch.value | ENC_PFX4;
        push_job.len_m1 = 2'd3;
      end else begin
        push_job.kind = KIND_ENC_ERR;
      end
    end else if (bytes_left_r == 2'd0) begin
      // first byte: prefix sets the length
      if (!b[7]) begin
        has_result    = 1'b1;
        push_job.kind = KIND_NUMBER;
        push_job.data = {24'd0, b};
      end else if (b[7:6] == 2'b10) begin
        acc_nxt        = {22'd0, b[5:0]};
        bytes_left_nxt = 2'd1;
      end else if (b[7:5] == 3'b110) begin
        acc_nxt        = {23'd0, b[4:0]};
        bytes_left_nxt = 2'd2;
      end else if (b[7:4] == 4'b1110) begin
        acc_nxt        = {24'd0, b[3:0]};
        bytes_left_nxt = 2'd3;
      end else begin
        // bad prefix, stay waiting for a first byte
        acc_nxt       = 28'd0;
        has_result    = 1'b1;
        push_job.kind = KIND_DEC_ERR;
      end
    end else begin
      acc_nxt        = {acc_r[19:0], b};
      bytes_left_nxt = bytes_left_r - 2'd1;
      if (bytes_left_r == 2'd1) begin
        has_result    = 1'b1;
        push_job.kind = KIND_NUMBER;
        push_job.data = {4'd0, acc_nxt};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_left_r <= 2'd0;
      acc_r        <= 28'd0;
    end else if (accept && in_ch.op == OP_DECODE) begin
      bytes_left_r <= bytes_left_nxt;
      acc_r        <= acc_nxt;
    end
  end

endmodule

@@ hdl/pvc_queue.sv @@
// small job queue between the front and back ends
// depends on pvc_pkg
module pvc_queue #(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  pvc_pkg::job_t push_job,
  input  logic          pop,
  output pvc_pkg::job_t head_job,
  output logic          full,
  output logic          empty
);
  import pvc_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  job_t          slots_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          do_pop;

  assign full     = (count_r == FULL_CNT);
  assign empty    = (count_r == '0);
  assign head_job = slots_r[rd_ptr_r];
  assign do_pop   = pop && !empty;

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (!push && do_pop) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

@@ hdl/pvc_back.sv @@
// back end: walks queued jobs into result words through an output register
// depends on pvc_pkg and pvc_out_if
module pvc_back (
  input  logic          clk,
  input  logic          rst_n,
  input  pvc_pkg::job_t head_job,
  input  logic          q_empty,
  output logic          pop,
  pvc_out_if.source     out_ch
);
  import pvc_pkg::*;

  logic        out_valid_r;
  logic [1:0]  kind_r;
  logic [7:0]  byte_r;
  logic [27:0] number_r;
  logic        last_r;
  logic [1:0]  idx_r;
  logic        load, take;
  logic        is_last;
  logic [1:0]  sel;
  logic [7:0]  byte_sel;

  assign load    = !out_valid_r || out_ch.ready;
  assign take    = load && !q_empty;
  assign is_last = (idx_r == head_job.len_m1);
  assign pop     = take && is_last;
  assign sel     = head_job.len_m1 - idx_r;

  // most significant byte first
  always_comb begin
    case (sel)
      2'd0:    byte_sel = head_job.data[7:0];
      2'd1:    byte_sel = head_job.data[15:8];
      2'd2:    byte_sel = head_job.data[23:16];
      2'd3:    byte_sel = head_job.data[31:24];
      default: byte_sel = 8'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= 2'd0;
    end else if (load) begin
      out_valid_r <= !q_empty;
      if (take) begin
        idx_r <= is_last ? 2'd0 : idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      kind_r   <= head_job.kind;
      byte_r   <= (head_job.kind == KIND_BYTE) ? byte_sel : 8'd0;
      number_r <= (head_job.kind == KIND_NUMBER) ? head_job.data[27:0] : 28'd0;
      last_r   <= is_last;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.kind     = kind_r;
  assign out_ch.out_byte = byte_r;
  assign out_ch.number   = number_r;
  assign out_ch.last     = last_r;

endmodule

@@ hdl/prefix_varint_codec.sv @@
// datapath: accepted words become jobs in a QUEUE_DEPTH job queue that absorbs bursts
// throughput: one decode byte per cycle unless the queue is full; an encode word yields
//   1 to 4 bytes, one per cycle while out_ch.ready, bounded by the single result register
// reset: synchronous, active low; clears decode state, queue pointers and result valid
// top level of the prefix-length varint codec; depends on pvc_pkg, pvc_if and pvc modules
module prefix_varint_codec #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic     clk,
  input  logic     rst_n,
  pvc_in_if.sink   in_ch,
  pvc_out_if.source out_ch
);
  import pvc_pkg::*;

  // front to queue
  logic push;
  job_t push_job;
  logic q_full;

  // queue to back
  job_t head_job;
  logic q_empty;
  logic pop;

  // front: classifies each word, keeps the partial decode number,
  // and only pushes a job when the word produces results
  pvc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .q_full   (q_full),
    .push     (push),
    .push_job (push_job)
  );

  // queue decouples input acceptance from multi-byte encode output
  pvc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .full     (q_full),
    .empty    (q_empty)
  );

  // back: emits one result word per cycle from the queue head while out_ch is ready,
  // popping the job with its last word
  pvc_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head_job (head_job),
    .q_empty  (q_empty),
    .pop      (pop),
    .out_ch   (out_ch)
  );

endmodule
